// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the scheduler RTL. They compile to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked at every rising clock edge outside of reset.
`define TDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define TDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TDS_ASSERT(label, clk, rst, prop, msg)
`define TDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// Task dependency scheduler package
// Command and status codes, field widths and default table size.
// ----------------------------------------------------------------------------
package tds_pkg;

   localparam int MAX_TASKS_DEF = 16;

   localparam int CMD_W     = 2;
   localparam int SLOT_ID_W = 4;
   localparam int STATUS_W  = 2;
   localparam int LIVE_W    = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE   = 2'd0,
      CMD_DEPEND   = 2'd1,
      CMD_GRAB     = 2'd2,
      CMD_COMPLETE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_NONE_READY = 2'd2,
      STATUS_BAD_SLOT   = 2'd3
   } status_type;

endpackage

// ===== rtl/tds_channels.sv =====
// ----------------------------------------------------------------------------
// Scheduler channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface tds_req_if import tds_pkg::*;;
   logic                 valid;
   logic                 ready;
   cmd_type              cmd;
   logic [SLOT_ID_W-1:0] task_a;
   logic [SLOT_ID_W-1:0] task_b;

   modport source (output valid, output cmd, output task_a, output task_b, input ready);
   modport sink   (input valid, input cmd, input task_a, input task_b, output ready);
endinterface

interface tds_rsp_if import tds_pkg::*;;
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [SLOT_ID_W-1:0] task_id;
   logic [LIVE_W-1:0]    live_count;

   modport source (output valid, output status, output task_id, output live_count,
                   input ready);
   modport sink   (input valid, input status, input task_id, input live_count,
                   output ready);
endinterface

// ===== rtl/tds_lowest_pick.sv =====
// ----------------------------------------------------------------------------
// Lowest set bit picker
// Finds the lowest set bit of a request vector and returns its index.
// ----------------------------------------------------------------------------
module tds_lowest_pick import tds_pkg::*; #(
   parameter  int WIDTH = MAX_TASKS_DEF,
   localparam int IDX_W = $clog2(WIDTH)
) (
   input  logic [WIDTH-1:0] req_vec,
   output logic             found,
   output logic [IDX_W-1:0] index
);

   logic [WIDTH-1:0] lowest;

   // Two's complement trick isolates the lowest set bit as a one-hot word.
   assign lowest = req_vec & (~req_vec + WIDTH'(1));
   assign found  = |req_vec;

   always_comb begin
      index = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (lowest[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

// ===== rtl/task_dependency_scheduler.sv =====
// ----------------------------------------------------------------------------
// Task dependency scheduler
// A command item is taken into the input register, then executes into the
// result register once that is empty or being emptied. Throughput: one item
// per cycle while the result side keeps up.
// Reset is synchronous and active high; it frees every slot at once, so the
// block takes items as soon as reset is released, with no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module task_dependency_scheduler import tds_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tds_req_if.sink   req_chan,
   tds_rsp_if.source rsp_chan
);

   // Slot index width, a width wide enough for both the slot index and the
   // item fields, and the width of the live task counter.
   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int AW    = (IDX_W > SLOT_ID_W) ? IDX_W : SLOT_ID_W;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   // The scoreboard. Row i of waits_on holds the parents that slot i waits
   // on; row i of older_than holds the slots that were created before it.
   logic [MAX_TASKS-1:0] slot_valid_ff,   slot_valid_in;
   logic [MAX_TASKS-1:0] slot_running_ff, slot_running_in;
   logic [MAX_TASKS-1:0] waits_on_ff   [MAX_TASKS];
   logic [MAX_TASKS-1:0] waits_on_in   [MAX_TASKS];
   logic [MAX_TASKS-1:0] older_than_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] older_than_in [MAX_TASKS];
   logic [CNT_W-1:0]     live_ff, live_in;

   // Input register.
   logic                 in_vld_ff;
   cmd_type              in_cmd_ff;
   logic [SLOT_ID_W-1:0] in_a_ff;
   logic [SLOT_ID_W-1:0] in_b_ff;

   // Result register.
   logic                 out_vld_ff;
   status_type           out_status_ff, out_status_in;
   logic [SLOT_ID_W-1:0] out_id_ff,     out_id_in;
   logic [LIVE_W-1:0]    out_live_ff;

   logic                 fire;
   logic                 load;

   // The item in the input register executes when the result register is
   // empty or is being emptied in this cycle. The input register takes a new
   // item as its current one executes, one per cycle unless the sink stalls.
   assign fire           = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || fire;
   assign load           = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_cmd_ff <= req_chan.cmd;
         in_a_ff   <= req_chan.task_a;
         in_b_ff   <= req_chan.task_b;
      end
   end

   // Slot operands. A slot number is usable only below MAX_TASKS; the
   // truncated index is read only where that check has passed.
   logic [AW-1:0]    a_ext, b_ext;
   logic [IDX_W-1:0] a_idx, b_idx;
   logic             a_ok, b_ok;

   assign a_ext = AW'(in_a_ff);
   assign b_ext = AW'(in_b_ff);
   assign a_ok  = int'(a_ext) < MAX_TASKS;
   assign b_ok  = int'(b_ext) < MAX_TASKS;
   assign a_idx = a_ext[IDX_W-1:0];
   assign b_idx = b_ext[IDX_W-1:0];

   // A slot is ready when it is valid, idle and has no pending parents. The
   // oldest ready slot is the one with no ready slot among its elders; since
   // creation order is total there is at most one such slot.
   logic [MAX_TASKS-1:0] ready_vec;
   logic [MAX_TASKS-1:0] oldest_vec;

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         ready_vec[i] = slot_valid_ff[i] && !slot_running_ff[i] && !(|waits_on_ff[i]);
      end
      for (int i = 0; i < MAX_TASKS; i++) begin
         oldest_vec[i] = ready_vec[i] && ((older_than_ff[i] & ready_vec) == '0);
      end
   end

   logic             free_found, grab_found;
   logic [IDX_W-1:0] free_idx,   grab_idx;

   tds_lowest_pick #(
      .WIDTH   (MAX_TASKS)
   ) u_free_pick (
      .req_vec (~slot_valid_ff),
      .found   (free_found),
      .index   (free_idx)
   );

   tds_lowest_pick #(
      .WIDTH   (MAX_TASKS)
   ) u_grab_pick (
      .req_vec (oldest_vec),
      .found   (grab_found),
      .index   (grab_idx)
   );

   // Command execution. Every command updates the scoreboard in place and
   // produces its status; a failing command leaves the scoreboard as it was.
   logic [IDX_W-1:0] id_idx;

   always_comb begin
      slot_valid_in   = slot_valid_ff;
      slot_running_in = slot_running_ff;
      waits_on_in     = waits_on_ff;
      older_than_in   = older_than_ff;
      live_in         = live_ff;
      out_status_in   = STATUS_OK;
      id_idx          = '0;

      case (in_cmd_ff)
         CMD_CREATE: begin
            if (free_found) begin
               // The new slot leaves every row, then becomes the youngest:
               // all slots valid now are older than it.
               for (int i = 0; i < MAX_TASKS; i++) begin
                  waits_on_in[i][free_idx]   = 1'b0;
                  older_than_in[i][free_idx] = 1'b0;
               end
               slot_valid_in[free_idx]   = 1'b1;
               slot_running_in[free_idx] = 1'b0;
               waits_on_in[free_idx]     = '0;
               older_than_in[free_idx]   = slot_valid_ff;
               live_in                   = live_ff + CNT_W'(1);
               id_idx                    = free_idx;
            end else begin
               out_status_in = STATUS_FULL;
            end
         end
         CMD_DEPEND: begin
            if (a_ok && b_ok && (a_ext != b_ext) &&
                slot_valid_ff[a_idx] && slot_valid_ff[b_idx]) begin
               waits_on_in[a_idx][b_idx] = 1'b1;
            end else begin
               out_status_in = STATUS_BAD_SLOT;
            end
         end
         CMD_GRAB: begin
            if (grab_found) begin
               slot_running_in[grab_idx] = 1'b1;
               id_idx                    = grab_idx;
            end else begin
               out_status_in = STATUS_NONE_READY;
            end
         end
         CMD_COMPLETE: begin
            if (a_ok && slot_valid_ff[a_idx] && slot_running_ff[a_idx]) begin
               // Clearing the column releases every task that waited on it.
               slot_valid_in[a_idx]   = 1'b0;
               slot_running_in[a_idx] = 1'b0;
               waits_on_in[a_idx]     = '0;
               older_than_in[a_idx]   = '0;
               for (int i = 0; i < MAX_TASKS; i++) begin
                  waits_on_in[i][a_idx]   = 1'b0;
                  older_than_in[i][a_idx] = 1'b0;
               end
               live_in = live_ff - CNT_W'(1);
            end else begin
               out_status_in = STATUS_BAD_SLOT;
            end
         end
         default: begin
            out_status_in = STATUS_BAD_SLOT;
         end
      endcase

      // Only create and grab report a slot, and only when they succeed.
      if ((out_status_in == STATUS_OK) &&
          ((in_cmd_ff == CMD_CREATE) || (in_cmd_ff == CMD_GRAB))) begin
         out_id_in = SLOT_ID_W'(id_idx);
      end else begin
         out_id_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff   <= '0;
         slot_running_ff <= '0;
         live_ff         <= '0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            waits_on_ff[i]   <= '0;
            older_than_ff[i] <= '0;
         end
      end else if (fire) begin
         slot_valid_ff   <= slot_valid_in;
         slot_running_ff <= slot_running_in;
         live_ff         <= live_in;
         waits_on_ff     <= waits_on_in;
         older_than_ff   <= older_than_in;
      end
   end

   // The result register holds its item until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (fire) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_status_ff <= out_status_in;
         out_id_ff     <= out_id_in;
         out_live_ff   <= LIVE_W'(live_in);
      end
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.status     = out_status_ff;
   assign rsp_chan.task_id    = out_id_ff;
   assign rsp_chan.live_count = out_live_ff;

   // A running slot is always a valid slot.
   `TDS_ASSERT(a_running_valid, clock, reset,
      ((slot_running_ff & ~slot_valid_ff) == '0), "running bit set on a free slot")

   // The live counter tracks the number of valid slots.
   `TDS_ASSERT(a_live_count, clock, reset,
      ($countones(slot_valid_ff) == int'(live_ff)), "live counter out of step")

   // A failed command never reports a slot.
   `TDS_ASSERT(a_fail_no_id, clock, reset,
      (!out_vld_ff || (out_status_ff == STATUS_OK) || (out_id_ff == '0)),
      "nonzero task id with failing status")

   // A successful grab leaves the granted slot running.
   `TDS_ASSERT_NEXT(a_grab_runs, clock, reset,
      (fire && (in_cmd_ff == CMD_GRAB) && grab_found),
      slot_running_ff[$past(grab_idx)], "granted slot not marked running")

endmodule

// ===== tb/task_dependency_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// Task dependency scheduler testbench
// Drives command items into the scheduler and checks every result item
// against a scoreboard that keeps its own copy of the slot table. A short
// directed sequence covers empty, full and bad-slot cases. Random phases of
// well-formed task lifecycles with some noise follow, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module task_dependency_scheduler_test;
   import tds_pkg::*;

   localparam int SLOTS = MAX_TASKS_DEF;

   typedef struct packed {
      status_type           status;
      logic [SLOT_ID_W-1:0] task_id;
      logic [LIVE_W-1:0]    live_count;
   } sched_result_type;

   // The scoreboard mirrors the slot table. Each accepted command item is
   // applied to the mirror at once, and the result that it must produce is
   // queued until the matching result item leaves the block.
   class sched_scoreboard;
      bit [SLOTS-1:0]   valid_mask;
      bit [SLOTS-1:0]   running_mask;
      bit [SLOTS-1:0]   waits_on [SLOTS];
      bit [SLOTS-1:0]   older_than [SLOTS];
      sched_result_type expected_results [$];
      int               errors;

      function new();
         valid_mask   = '0;
         running_mask = '0;
         for (int i = 0; i < SLOTS; i++) begin
            waits_on[i]   = '0;
            older_than[i] = '0;
         end
         errors = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Returns a random slot whose bit is set in the mask, or -1.
      function int pick_from(bit [SLOTS-1:0] mask);
         int n;
         int k;
         n = $countones(mask);
         if (n == 0) return -1;
         k = $urandom_range(0, n - 1);
         for (int i = 0; i < SLOTS; i++) begin
            if (mask[i]) begin
               if (k == 0) return i;
               k--;
            end
         end
         return -1;
      endfunction

      function void note_command(cmd_type c, logic [SLOT_ID_W-1:0] a,
                                 logic [SLOT_ID_W-1:0] b);
         sched_result_type r;
         int               s;
         bit [SLOTS-1:0]   ready;
         r.status  = STATUS_OK;
         r.task_id = '0;
         case (c)
            CMD_CREATE: begin
               s = -1;
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!valid_mask[i]) s = i;
               if (s < 0) begin
                  r.status = STATUS_FULL;
               end else begin
                  for (int i = 0; i < SLOTS; i++) begin
                     waits_on[i][s]   = 1'b0;
                     older_than[i][s] = 1'b0;
                  end
                  older_than[s]   = valid_mask;
                  waits_on[s]     = '0;
                  valid_mask[s]   = 1'b1;
                  running_mask[s] = 1'b0;
                  r.task_id       = s[SLOT_ID_W-1:0];
               end
            end
            CMD_DEPEND: begin
               if (a == b || !valid_mask[a] || !valid_mask[b])
                  r.status = STATUS_BAD_SLOT;
               else
                  waits_on[a][b] = 1'b1;
            end
            CMD_GRAB: begin
               ready = '0;
               for (int i = 0; i < SLOTS; i++)
                  ready[i] = valid_mask[i] && !running_mask[i] && waits_on[i] == '0;
               s = -1;
               for (int i = 0; i < SLOTS; i++)
                  if (s < 0 && ready[i] && (older_than[i] & ready) == '0) s = i;
               if (s < 0) begin
                  r.status = STATUS_NONE_READY;
               end else begin
                  running_mask[s] = 1'b1;
                  r.task_id       = s[SLOT_ID_W-1:0];
               end
            end
            default: begin
               if (!valid_mask[a] || !running_mask[a]) begin
                  r.status = STATUS_BAD_SLOT;
               end else begin
                  valid_mask[a]   = 1'b0;
                  running_mask[a] = 1'b0;
                  waits_on[a]     = '0;
                  older_than[a]   = '0;
                  for (int i = 0; i < SLOTS; i++) begin
                     waits_on[i][a]   = 1'b0;
                     older_than[i][a] = 1'b0;
                  end
               end
            end
         endcase
         if (r.status != STATUS_OK) r.task_id = '0;
         r.live_count = LIVE_W'($countones(valid_mask));
         expected_results = {expected_results, r};
      endfunction

      function void check_result(status_type st, logic [SLOT_ID_W-1:0] id,
                                 logic [LIVE_W-1:0] live);
         sched_result_type e;
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected: status %0d task_id %0d live %0d",
                   st, id, live);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            errors++;
         end
         if (id !== e.task_id) begin
            $error("task_id: expected %0d, got %0d", e.task_id, id);
            errors++;
         end
         if (live !== e.live_count) begin
            $error("live_count: expected %0d, got %0d", e.live_count, live);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   // Idling switches for the command side and the result side.
   bit idle_on  = 1'b1;
   bit stall_on = 1'b1;

   sched_scoreboard sb;

   tds_req_if req ();
   tds_rsp_if rsp ();

   task_dependency_scheduler uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always #6 clock = ~clock;

   // Both channels are watched at the rising edge. Inputs only move at the
   // falling edge, so what is seen here is stable for the whole edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            sb.note_command(req.cmd, req.task_a, req.task_b);
         if (rsp.valid && rsp.ready)
            sb.check_result(rsp.status, rsp.task_id, rsp.live_count);
      end
   end

   // The result side stalls at random, 16 percent of the time, while stalling is on.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= !(stall_on && $urandom_range(0, 99) < 16);
      end
   end

   // Offers one command item and returns at the falling edge after it was
   // taken. Valid stays high on return, so back-to-back items never lower
   // and raise it within one time step.
   task automatic send_command(input cmd_type c, input int a, input int b);
      while (idle_on && $urandom_range(0, 99) < 16) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid  <= 1'b1;
      req.cmd    <= c;
      req.task_a <= SLOT_ID_W'(a);
      req.task_b <= SLOT_ID_W'(b);
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   // Holds the command side off until every outstanding result has come back.
   task automatic drain_results();
      req.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Picks one command from the phase weights. Most items are well formed:
   // dependencies point from a younger task to an older one, so no cycle can
   // ever lock slots for good, and completes target running tasks. The rest
   // are bad slots, self dependencies and random complete targets.
   task automatic random_command(input int w_create, input int w_dep, input int w_grab);
      int             roll;
      int             a;
      int             b;
      bit [SLOTS-1:0] cand;
      roll = $urandom_range(0, 99);
      if (roll < w_create) begin
         send_command(CMD_CREATE, $urandom_range(0, 15), $urandom_range(0, 15));
      end else if (roll < w_create + w_dep) begin
         cand = '0;
         for (int i = 0; i < SLOTS; i++)
            cand[i] = sb.valid_mask[i] && (sb.older_than[i] & sb.valid_mask) != '0;
         if (cand != '0 && $urandom_range(0, 99) < 85) begin
            a = sb.pick_from(cand);
            b = sb.pick_from(sb.older_than[a] & sb.valid_mask);
         end else if (sb.valid_mask != '1 && $urandom_range(0, 1) == 1) begin
            // One side names a free slot.
            a = $urandom_range(0, 15);
            b = sb.pick_from(~sb.valid_mask);
            if ($urandom_range(0, 1) == 1) begin
               b = a;
               a = sb.pick_from(~sb.valid_mask);
            end
         end else begin
            a = $urandom_range(0, 15);
            b = a;
         end
         send_command(CMD_DEPEND, a, b);
      end else if (roll < w_create + w_dep + w_grab) begin
         send_command(CMD_GRAB, $urandom_range(0, 15), $urandom_range(0, 15));
      end else begin
         if (sb.running_mask != '0 && $urandom_range(0, 99) < 85)
            a = sb.pick_from(sb.running_mask);
         else
            a = $urandom_range(0, 15);
         send_command(CMD_COMPLETE, a, $urandom_range(0, 15));
      end
   endtask

   initial begin
      sb         = new();
      req.valid  = 1'b0;
      req.cmd    = CMD_CREATE;
      req.task_a = '0;
      req.task_b = '0;
      reset      = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. On an empty table a grab finds nothing ready, and
      // complete and depend see only free slots.
      send_command(CMD_GRAB, 15, 15);
      send_command(CMD_COMPLETE, 15, 0);
      send_command(CMD_DEPEND, 15, 0);
      // Fill every slot, then one more create hits the full table.
      for (int i = 0; i <= SLOTS; i++)
         send_command(CMD_CREATE, $urandom_range(0, 15), $urandom_range(0, 15));
      // Slot 1 waits on slot 0; setting the same bit twice changes nothing.
      send_command(CMD_DEPEND, 1, 0);
      send_command(CMD_DEPEND, 1, 0);
      send_command(CMD_DEPEND, 3, 3);
      send_command(CMD_GRAB, 0, 0);
      // Slot 0 is running now; a dependency on it as the waiter is recorded
      // but has no effect, since completion clears its row.
      send_command(CMD_DEPEND, 0, 15);
      send_command(CMD_COMPLETE, 1, 0);
      send_command(CMD_COMPLETE, 0, 0);
      send_command(CMD_GRAB, 15, 15);

      // Random phases cycle through filling, draining and balanced weights.
      // Phase 3 runs with no idling on either side, and the command side
      // waits for all results to return after several phases.
      for (int phase = 0; phase < 8; phase++) begin
         idle_on  = (phase != 3);
         stall_on = (phase != 3);
         for (int n = 0; n < 100; n++) begin
            case (phase % 3)
               0:       random_command(40, 25, 20);
               1:       random_command(10, 20, 30);
               default: random_command(25, 25, 25);
            endcase
         end
         if (phase % 3 == 1) drain_results();
      end
      idle_on  = 1'b1;
      stall_on = 1'b1;

      req.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      // Waiting on after the drain lets a stray result item still be caught.
      repeat (8) @(negedge clock);
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
